### rtl/core/rsi_pkg.sv
// ============================================================================
// rsi_pkg : shared types and constants for the ray/sphere intersect block
// Beat layouts, stage side-band record and result record.
// ============================================================================
package rsi_pkg;

    localparam int IN_TDATA_W  = 280;
    localparam int OUT_TDATA_W = 128;

    localparam int BQ_W   = 53;   // rel . dir, Q21.32 signed
    localparam int Q_W    = 105;  // non-negative discriminant, Q41.64
    localparam int REM_W  = 108;  // root remainder width
    localparam int ROOT_W = 53;   // integer root, Q21.32

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // One input beat, unpacked.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [17:0] dz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [30:0] radius;
    } in_t;

    // Data that rides along the pipe next to the arithmetic.
    typedef struct packed {
        logic signed [31:0]     sx;
        logic signed [31:0]     sy;
        logic signed [31:0]     sz;
        logic signed [17:0]     dx;
        logic signed [17:0]     dy;
        logic signed [17:0]     dz;
        logic signed [BQ_W-1:0] bq;
        logic                   miss;
    } side_t;

    typedef struct packed {
        logic               hit;
        logic        [30:0] distance;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } result_t;

endpackage

### rtl/core/rsi_front.sv
// ============================================================================
// rsi_front : dot products and discriminant
// Seven stages: rel, products, sums, magnitude, partial squares, b^2, q.
// ============================================================================
module rsi_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rsi_pkg::in_t                in_item,
    output logic                        out_valid,
    output rsi_pkg::side_t              out_side,
    output logic [rsi_pkg::Q_W-1:0]     out_q
);

    logic [7:1]                v_reg;
    rsi_pkg::side_t            sd_reg [1:7];

    logic signed [31:0]        st_c   [3];
    logic signed [31:0]        ce_c   [3];
    logic signed [17:0]        dr_c   [3];
    logic signed [32:0]        rel_c  [3];
    logic        [32:0]        relm_c [3];

    logic signed [32:0]        rel_reg  [3];
    logic        [32:0]        relm_reg [3];
    logic signed [17:0]        dir_reg  [3];
    logic        [30:0]        rad_reg;
    logic signed [50:0]        pb_reg   [3];
    logic        [65:0]        pc_reg   [3];
    logic        [61:0]        prad_reg;
    logic signed [67:0]        cq3_reg, cq4_reg, cq5_reg, cq6_reg;
    logic        [51:0]        bmag_reg;
    logic                      miss4_reg, miss5_reg, miss6_reg;
    logic        [51:0]        hh_reg, hl_reg, ll_reg;
    logic        [103:0]       bsq_reg;
    logic        [rsi_pkg::Q_W-1:0] q_reg;
    logic signed [105:0]       q_c;

    always_comb
    begin
        st_c[0] = in_item.sx;  st_c[1] = in_item.sy;  st_c[2] = in_item.sz;
        ce_c[0] = in_item.cx;  ce_c[1] = in_item.cy;  ce_c[2] = in_item.cz;
        dr_c[0] = in_item.dx;  dr_c[1] = in_item.dy;  dr_c[2] = in_item.dz;
        for (int i = 0; i < 3; i++)
        begin
            rel_c[i]  = $signed({st_c[i][31], st_c[i]}) - $signed({ce_c[i][31], ce_c[i]});
            relm_c[i] = rel_c[i][32] ? 33'(-rel_c[i]) : rel_c[i];
        end
    end

    assign q_c = $signed({2'b00, bsq_reg}) - $signed({{6{cq6_reg[67]}}, cq6_reg, 32'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            for (int i = 0; i < 3; i++)
            begin
                rel_reg[i]  <= rel_c[i];
                relm_reg[i] <= relm_c[i];
                dir_reg[i]  <= dr_c[i];
            end
            rad_reg        <= in_item.radius;
            sd_reg[1].sx   <= in_item.sx;
            sd_reg[1].sy   <= in_item.sy;
            sd_reg[1].sz   <= in_item.sz;
            sd_reg[1].dx   <= in_item.dx;
            sd_reg[1].dy   <= in_item.dy;
            sd_reg[1].dz   <= in_item.dz;
            sd_reg[1].bq   <= '0;
            sd_reg[1].miss <= 1'b0;
            // stage 2
            for (int i = 0; i < 3; i++)
            begin
                pb_reg[i] <= rel_reg[i] * dir_reg[i];
                pc_reg[i] <= relm_reg[i] * relm_reg[i];
            end
            prad_reg <= rad_reg * rad_reg;
            // stage 3
            cq3_reg <= $signed({2'b00, pc_reg[0]}) + $signed({2'b00, pc_reg[1]})
                     + $signed({2'b00, pc_reg[2]}) - $signed({6'b0, prad_reg});
            // stage 4
            bmag_reg  <= sd_reg[3].bq[52] ? 52'(-sd_reg[3].bq) : sd_reg[3].bq[51:0];
            miss4_reg <= !cq3_reg[67] && (cq3_reg != '0)
                      && !sd_reg[3].bq[52] && (sd_reg[3].bq != '0);
            cq4_reg   <= cq3_reg;
            // stage 5
            hh_reg    <= bmag_reg[51:26] * bmag_reg[51:26];
            hl_reg    <= bmag_reg[51:26] * bmag_reg[25:0];
            ll_reg    <= bmag_reg[25:0] * bmag_reg[25:0];
            miss5_reg <= miss4_reg;
            cq5_reg   <= cq4_reg;
            // stage 6
            bsq_reg   <= {hh_reg, 52'b0} + {25'b0, hl_reg, 27'b0} + {52'b0, ll_reg};
            miss6_reg <= miss5_reg;
            cq6_reg   <= cq5_reg;
            // stage 7: negative q is a miss; feed the root a zero then
            q_reg <= q_c[105] ? '0 : q_c[104:0];
            sd_reg[2] <= sd_reg[1];
            sd_reg[3] <= '{sx: sd_reg[2].sx, sy: sd_reg[2].sy, sz: sd_reg[2].sz,
                           dx: sd_reg[2].dx, dy: sd_reg[2].dy, dz: sd_reg[2].dz,
                           bq: pb_reg[0] + pb_reg[1] + pb_reg[2],
                           miss: sd_reg[2].miss};
            for (int j = 4; j <= 6; j++)
            begin
                sd_reg[j] <= sd_reg[j-1];
            end
            sd_reg[7] <= '{sx: sd_reg[6].sx, sy: sd_reg[6].sy, sz: sd_reg[6].sz,
                           dx: sd_reg[6].dx, dy: sd_reg[6].dy, dz: sd_reg[6].dz,
                           bq: sd_reg[6].bq,
                           miss: miss6_reg | q_c[105]};
        end
    end

    assign out_valid = v_reg[7];
    assign out_side  = sd_reg[7];
    assign out_q     = q_reg;

endmodule

### rtl/core/rsi_sqrt.sv
// ============================================================================
// rsi_sqrt : pipelined integer square root
// One root bit per stage, restoring remainder form, msb first.
// ============================================================================
module rsi_sqrt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  rsi_pkg::side_t                 in_side,
    input  logic [rsi_pkg::Q_W-1:0]        in_q,
    output logic                           out_valid,
    output rsi_pkg::side_t                 out_side,
    output logic [rsi_pkg::ROOT_W-1:0]     out_root
);

    localparam int N = rsi_pkg::ROOT_W;
    localparam int RW = rsi_pkg::REM_W;

    logic                  v_reg  [1:N];
    logic [RW-1:0]         r_reg  [1:N];
    logic [N-1:0]          s_reg  [1:N];
    rsi_pkg::side_t        sd_reg [1:N];

    for (genvar j = 0; j < N; j++)
    begin : g_step
        localparam int K = N - 1 - j;

        logic               v_cur;
        logic [RW-1:0]      r_cur;
        logic [N-1:0]       s_cur;
        rsi_pkg::side_t     sd_cur;
        logic [RW-1:0]      trial;
        logic               take;

        if (j == 0)
        begin : g_first
            assign v_cur  = in_valid;
            assign r_cur  = {{(RW - rsi_pkg::Q_W){1'b0}}, in_q};
            assign s_cur  = '0;
            assign sd_cur = in_side;
        end
        else
        begin : g_next
            assign v_cur  = v_reg[j];
            assign r_cur  = r_reg[j];
            assign s_cur  = s_reg[j];
            assign sd_cur = sd_reg[j];
        end

        // (s + 2^k)^2 - s^2 = (2s + 2^k) * 2^k
        assign trial = ({{(RW - N){1'b0}}, s_cur} << (K + 1)) | ({{(RW - 1){1'b0}}, 1'b1} << (2 * K));
        assign take  = (r_cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j+1]  <= take ? r_cur - trial : r_cur;
                s_reg[j+1]  <= take ? (s_cur | ({{(N - 1){1'b0}}, 1'b1} << K)) : s_cur;
                sd_reg[j+1] <= sd_cur;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_side  = sd_reg[N];
    assign out_root  = s_reg[N];

endmodule

### rtl/core/rsi_back.sv
// ============================================================================
// rsi_back : hit distance and hit point
// Four stages: t, clamp and saturate, t*dir, floor, add and saturate.
// ============================================================================
module rsi_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  rsi_pkg::side_t                 in_side,
    input  logic [rsi_pkg::ROOT_W-1:0]     in_root,
    output logic                           out_valid,
    output rsi_pkg::result_t               out_res
);

    logic [4:1]             v_reg;
    rsi_pkg::side_t         sd_reg [1:3];
    logic signed [54:0]     tf_reg;
    logic        [38:0]     tq_reg;
    logic        [30:0]     d2_reg, d3_reg;
    logic signed [17:0]     dir_c  [3];
    logic signed [31:0]     st_c   [3];
    logic signed [57:0]     pr_reg [3];
    logic signed [42:0]     sum_c  [3];
    logic signed [31:0]     pt_c   [3];
    rsi_pkg::result_t       res_reg;

    always_comb
    begin
        dir_c[0] = sd_reg[2].dx;  dir_c[1] = sd_reg[2].dy;  dir_c[2] = sd_reg[2].dz;
        st_c[0]  = sd_reg[3].sx;  st_c[1]  = sd_reg[3].sy;  st_c[2]  = sd_reg[3].sz;
        for (int i = 0; i < 3; i++)
        begin
            sum_c[i] = $signed({{11{st_c[i][31]}}, st_c[i]}) + $signed(pr_reg[i][57:16]);
            if (sum_c[i][42:31] == '0 || sum_c[i][42:31] == '1)
                pt_c[i] = sum_c[i][31:0];
            else if (sum_c[i][42])
                pt_c[i] = 32'sh8000_0000;
            else
                pt_c[i] = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: t = -b - root
            tf_reg    <= -$signed({{2{in_side.bq[52]}}, in_side.bq})
                       - $signed({2'b00, in_root});
            sd_reg[1] <= in_side;
            // stage 2: clamp at zero, drop fraction bits below Q16.16
            if (!tf_reg[54] && tf_reg != '0)
                tq_reg <= tf_reg[54:16];
            else
                tq_reg <= '0;
            d2_reg    <= (!tf_reg[54] && tf_reg[54:47] != '0) ? rsi_pkg::DIST_MAX
                       : (tf_reg[54] ? '0 : tf_reg[46:16]);
            sd_reg[2] <= sd_reg[1];
            // stage 3: t * dir
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= $signed({1'b0, tq_reg}) * dir_c[i];
            end
            d3_reg    <= d2_reg;
            sd_reg[3] <= sd_reg[2];
            // stage 4: start + floor(t*dir), saturate, zero on miss
            if (sd_reg[3].miss)
            begin
                res_reg <= '0;
            end
            else
            begin
                res_reg.hit      <= 1'b1;
                res_reg.distance <= d3_reg;
                res_reg.px       <= pt_c[0];
                res_reg.py       <= pt_c[1];
                res_reg.pz       <= pt_c[2];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign out_res   = res_reg;

endmodule

### rtl/core/ray_sphere_intersect.sv
// ============================================================================
// ray_sphere_intersect : streaming ray against sphere test, Q16.16
// Fully pipelined first-hit distance and hit point for one ray per beat.
// ============================================================================
// Usage:
//   s_* channel takes one beat per ray: start point, unit direction, sphere
//   center and radius. m_* channel returns one beat per ray, in order:
//   m_tuser is the hit flag, m_tdata the distance and hit point. A miss
//   returns an all-zero beat.
//   Throughput: one beat per cycle, sustained, with no backpressure.
//   Pipeline: 7 stages of dot products and discriminant, 53 stages of
//   square root (one root bit per stage, set by the 53-bit Q21.32 root),
//   4 stages of distance and point, and the output register.
//   Stall: the output register is backed by a one-beat skid buffer. While
//   m_tready is low the pipe keeps moving until the skid fills; then the
//   whole pipe holds and s_tready drops. No beat is lost or repeated.
//   Reset: rst_n clears all valid bits; in-flight beats are dropped. The
//   block holds no other state.
// ============================================================================
module ray_sphere_intersect
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, start_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z, radius, zero pad
    input  logic [rsi_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance, point_x, point_y, point_z, zero pad
    output logic [rsi_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // hit
    output logic                              m_tuser
);

    rsi_pkg::in_t                     in_item;
    logic                             en;

    logic                             f_valid;
    rsi_pkg::side_t                   f_side;
    logic [rsi_pkg::Q_W-1:0]          f_q;
    logic                             r_valid;
    rsi_pkg::side_t                   r_side;
    logic [rsi_pkg::ROOT_W-1:0]       r_root;
    logic                             b_valid;
    rsi_pkg::result_t                 b_res;

    logic                             out_valid_reg;
    rsi_pkg::result_t                 out_reg;
    logic                             skid_valid_reg;
    rsi_pkg::result_t                 skid_reg;

    assign in_item.sx     = s_tdata[31:0];
    assign in_item.sy     = s_tdata[63:32];
    assign in_item.sz     = s_tdata[95:64];
    assign in_item.dx     = s_tdata[113:96];
    assign in_item.dy     = s_tdata[131:114];
    assign in_item.dz     = s_tdata[149:132];
    assign in_item.cx     = s_tdata[181:150];
    assign in_item.cy     = s_tdata[213:182];
    assign in_item.cz     = s_tdata[245:214];
    assign in_item.radius = s_tdata[276:246];

    // whole pipe advances unless the skid is holding a beat
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    rsi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_q     (f_q)
    );

    rsi_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_q      (f_q),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_root  (r_root)
    );

    rsi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .in_root   (r_root),
        .out_valid (b_valid),
        .out_res   (b_res)
    );

    // output register plus skid: a pipe beat is taken whenever en is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= b_valid;
            end
        end
        else if (b_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : b_res;
        end
        else if (b_valid && !skid_valid_reg)
        begin
            skid_reg <= b_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {1'b0, out_reg.pz, out_reg.py, out_reg.px, out_reg.distance};

    // skid only ever fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat with no output beat");

    // a held skid beat stays until the receiver takes the output
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid beat lost during stall");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss beat with nonzero payload");

    // pipe must hold while skid is full
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && b_valid) |=> b_valid)
        else $error("pipe beat dropped while skid full");

endmodule
